@@ rtl/cra_pkg.sv @@
// ----------------------------------------------------------------------------
// cra_pkg
// shared constants, item codes and payload types of the chunk reassembly engine
// ----------------------------------------------------------------------------
`default_nettype none

package cra_pkg;

	localparam int BYTES_PER_CHUNK = 128;
	localparam int MAX_PIECES      = 32;
	localparam int BUF_ADDR_W      = 12;
	localparam int BUF_DATA_W      = 8;
	localparam int PIECE_W         = $clog2(MAX_PIECES + 1);
	localparam int POS_W           = 8;
	localparam int MASK_W          = 32;
	localparam int TICK_W          = 16;
	localparam int MLEN_W          = 13;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

	typedef enum logic [2:0] {
		KIND_BYTE = 3'd0,
		KIND_END  = 3'd1,
		KIND_TICK = 3'd2,
		KIND_PEER = 3'd3,
		KIND_READ = 3'd4
	} kind_t;

	localparam logic [1:0] ERR_TIMEOUT = 2'd0;
	localparam logic [1:0] ERR_BAD     = 2'd1;
	localparam logic [1:0] ERR_PEER    = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  chunk_index;
		logic [7:0]  chunk_total;
		logic [7:0]  data_byte;
		logic [7:0]  peer_code;
		logic [11:0] read_address;
	} item_t;

	typedef struct packed {
		logic        ack_valid;
		logic [4:0]  ack_index;
		logic        complete;
		logic [12:0] message_length;
		logic        error_valid;
		logic [1:0]  error_kind;
		logic [7:0]  error_peer_code;
		logic [7:0]  read_data;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/cra_ram.sv @@
// ----------------------------------------------------------------------------
// cra_ram
// single-port synchronous ram, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cra_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/chunk_reassembly_engine.sv @@
// ----------------------------------------------------------------------------
// chunk_reassembly_engine
// reassembles a message from indexed chunks, one byte per item, into a
// 4096-byte buffer; acks chunks, reports completion, errors and buffer reads
// ----------------------------------------------------------------------------
// Busy stays low, so an item may be started in every cycle. An item that
// gives a result (chunk end, peer error, buffer read, a tick that times out)
// shows it on result for exactly one cycle with done high, in the cycle right
// after the item was accepted; the receiver cannot stall, so it must take
// each result in that cycle. Chunk bytes and buffer reads share the single
// port of the buffer ram, whose registered read data sets the result timing.
// The buffer has no reset: reading a byte that was never written returns an
// undefined value. The user writes the timeout register over its own channel
// (always ready) only while no item is in flight; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_reassembly_engine (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire cra_pkg::item_t          item,
	output logic                         done,
	output cra_pkg::result_t             result,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [15:0]             cfg_data
);

	import cra_pkg::*;

	// assembly state
	logic                  assembling_q, assembling_d;
	logic [PIECE_W-1:0]    expected_q, expected_d;
	logic [POS_W-1:0]      pos_q, pos_d;
	logic                  invalid_q, invalid_d;
	logic [POS_W-1:0]      fcl_q, fcl_d;
	logic [TICK_W-1:0]     idle_q, idle_d;
	logic [MASK_W-1:0]     rb_q, rb_d;
	logic [TICK_W-1:0]     timeout_q;

	// result register
	logic                  done_q, done_d;
	result_t               res_q, res_d;
	logic                  rd_sel_q;

	// buffer port
	logic                  ram_en, ram_we;
	logic [BUF_ADDR_W-1:0] ram_addr;
	logic [BUF_DATA_W-1:0] ram_rdata;

	logic                  accept;
	logic                  chunk_ok;
	logic [PIECE_W-1:0]    et_new;
	logic [MASK_W-1:0]     rb_new;
	logic [MASK_W-1:0]     full_mask;
	logic [POS_W-1:0]      fcl_new;
	logic [MLEN_W-1:0]     mlen;
	logic [TICK_W-1:0]     tick_next;
	logic [BUF_ADDR_W-1:0] wr_addr;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// valid chunk: total in range, index below total and below the stored total
	assign chunk_ok = (item.chunk_total != 8'd0)
		&& (item.chunk_total <= 8'(MAX_PIECES))
		&& (item.chunk_index < item.chunk_total)
		&& !(assembling_q && (item.chunk_index >= 8'(expected_q)));

	// byte address, wrapped to the buffer size
	assign wr_addr = BUF_ADDR_W'(16'(item.chunk_index) * 16'(BYTES_PER_CHUNK) + 16'(pos_q));

	// chunk end: first valid end opens the assembly with the announced total
	assign et_new  = assembling_q ? expected_q : PIECE_W'(item.chunk_total);
	assign rb_new  = (assembling_q ? rb_q : '0) | (MASK_W'(1) << item.chunk_index[4:0]);
	assign fcl_new = (8'(et_new) - 8'd1 == item.chunk_index) ? pos_q : fcl_q;

	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			full_mask[i] = (7'(i) < 7'(et_new));
		end
	end

	assign mlen = MLEN_W'((14'(et_new) - 14'd1) * 14'(BYTES_PER_CHUNK) + 14'(fcl_new));

	assign tick_next = idle_q + TICK_W'(1);

	// next state and result of the accepted item
	always_comb begin
		assembling_d = assembling_q;
		expected_d   = expected_q;
		pos_d        = pos_q;
		invalid_d    = invalid_q;
		fcl_d        = fcl_q;
		idle_d       = idle_q;
		rb_d         = rb_q;
		done_d       = 1'b0;
		res_d        = '0;
		ram_en       = 1'b0;
		ram_we       = 1'b0;
		ram_addr     = item.read_address;

		if (accept) begin
			case (item.kind)
				KIND_BYTE: begin
					if (!chunk_ok) begin
						invalid_d = 1'b1;
					end else if (pos_q < POS_W'(BYTES_PER_CHUNK)) begin
						ram_en   = 1'b1;
						ram_we   = 1'b1;
						ram_addr = wr_addr;
						pos_d    = pos_q + POS_W'(1);
					end
				end
				KIND_END: begin
					done_d    = 1'b1;
					pos_d     = '0;
					invalid_d = 1'b0;
					if (invalid_q || !chunk_ok) begin
						res_d.error_valid = 1'b1;
						res_d.error_kind  = ERR_BAD;
						assembling_d      = 1'b0;
						expected_d        = '0;
						fcl_d             = '0;
						idle_d            = '0;
						rb_d              = '0;
					end else begin
						res_d.ack_valid = 1'b1;
						res_d.ack_index = item.chunk_index[4:0];
						idle_d          = '0;
						if (rb_new == full_mask) begin
							// all chunks present: report and close the assembly
							res_d.complete       = 1'b1;
							res_d.message_length = mlen;
							assembling_d         = 1'b0;
							expected_d           = '0;
							fcl_d                = '0;
							rb_d                 = '0;
						end else begin
							assembling_d = 1'b1;
							expected_d   = et_new;
							fcl_d        = fcl_new;
							rb_d         = rb_new;
						end
					end
				end
				KIND_TICK: begin
					if (assembling_q) begin
						if (tick_next >= timeout_q) begin
							done_d            = 1'b1;
							res_d.error_valid = 1'b1;
							res_d.error_kind  = ERR_TIMEOUT;
							assembling_d      = 1'b0;
							expected_d        = '0;
							pos_d             = '0;
							invalid_d         = 1'b0;
							fcl_d             = '0;
							idle_d            = '0;
							rb_d              = '0;
						end else begin
							idle_d = tick_next;
						end
					end
				end
				KIND_PEER: begin
					done_d                = 1'b1;
					res_d.error_valid     = 1'b1;
					res_d.error_kind      = ERR_PEER;
					res_d.error_peer_code = item.peer_code;
					assembling_d          = 1'b0;
					expected_d            = '0;
					pos_d                 = '0;
					invalid_d             = 1'b0;
					fcl_d                 = '0;
					idle_d                = '0;
					rb_d                  = '0;
				end
				KIND_READ: begin
					// data arrives from the ram output register next cycle
					done_d = 1'b1;
					ram_en = 1'b1;
				end
				default: begin
					// unused kinds are ignored
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assembling_q <= 1'b0;
			expected_q   <= '0;
			pos_q        <= '0;
			invalid_q    <= 1'b0;
			fcl_q        <= '0;
			idle_q       <= '0;
			rb_q         <= '0;
			timeout_q    <= TIMEOUT_RESET;
			done_q       <= 1'b0;
			rd_sel_q     <= 1'b0;
		end else begin
			assembling_q <= assembling_d;
			expected_q   <= expected_d;
			pos_q        <= pos_d;
			invalid_q    <= invalid_d;
			fcl_q        <= fcl_d;
			idle_q       <= idle_d;
			rb_q         <= rb_d;
			done_q       <= done_d;
			rd_sel_q     <= accept && (item.kind == KIND_READ);
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	cra_ram #(
		.ADDR_W (BUF_ADDR_W),
		.DATA_W (BUF_DATA_W)
	) u_buffer (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (item.data_byte),
		.rdata (ram_rdata)
	);

	// read items take their byte straight from the ram output register
	always_comb begin
		result           = res_q;
		result.read_data = rd_sel_q ? ram_rdata : '0;
	end

	assign done = done_q;

	// a result only follows an accepted item
	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without accepted item");

	// completion is always reported together with its ack
	a_complete_has_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.complete) |-> result.ack_valid)
		else $error("completion without ack");

	// ack and error never share a result
	a_ack_xor_error: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.ack_valid && result.error_valid))
		else $error("ack and error in one result");

	// completion and errors leave the assembly cleared
	a_cleared_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.complete || result.error_valid))
			|-> (!assembling_q && (rb_q == '0) && (idle_q == '0)))
		else $error("assembly not cleared");

endmodule

`default_nettype wire

@@ sim/tb_chunk_reassembly_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunk_reassembly_engine
// self-checking bench: drives chunk bytes, chunk ends, ticks, peer errors and
// buffer reads with random gaps, predicts every ack, completion, error and
// read result, and compares them field by field as they come out
// ----------------------------------------------------------------------------

module tb_chunk_reassembly_engine;

	import cra_pkg::*;

	localparam int BUF_DEPTH = 1 << BUF_ADDR_W;
	localparam int KIND_LAST = 7;   // top of the 3-bit kind code, unused codes above read

	// ------------------------------------------------------------------------
	// scoreboard: mirror of the reassembly state plus queue of pending results
	// ------------------------------------------------------------------------
	class reasm_scoreboard;
		bit [7:0]          buf_mem [BUF_DEPTH];
		bit                buf_written [BUF_DEPTH];
		int                written_addrs[$];
		bit [MASK_W-1:0]   rx_mask;
		bit                assembling;
		bit [5:0]          exp_total;
		bit [POS_W-1:0]    byte_pos;
		bit                bad_bytes;
		bit [POS_W-1:0]    last_len;
		bit [TICK_W-1:0]   idle_ticks;
		bit [TICK_W-1:0]   timeout_ticks;
		result_t           pending_q[$];
		int                errors;

		function new();
			drop_assembly();
			timeout_ticks = TIMEOUT_RESET;
			errors = 0;
		endfunction

		function void drop_assembly();
			rx_mask    = '0;
			assembling = 1'b0;
			exp_total  = '0;
			byte_pos   = '0;
			bad_bytes  = 1'b0;
			last_len   = '0;
			idle_ticks = '0;
		endfunction

		function bit chunk_ok(bit [7:0] idx, bit [7:0] tot);
			if (tot == 0 || tot > MAX_PIECES || idx >= tot)
				return 1'b0;
			if (assembling && idx >= exp_total)
				return 1'b0;
			return 1'b1;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		// random address among the bytes that have been stored, -1 if none yet
		function int pick_written();
			if (written_addrs.size() == 0)
				return -1;
			return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
		endfunction

		// accepted input item: update the mirror and queue what it yields
		function void note_item(item_t it);
			result_t         r;
			int              a;
			bit              bad;
			bit [POS_W-1:0]  len;
			bit [MASK_W-1:0] full;
			r = '0;
			case (it.kind)
				KIND_BYTE: begin
					if (!chunk_ok(it.chunk_index, it.chunk_total)) begin
						bad_bytes = 1'b1;
					end else if (byte_pos < BYTES_PER_CHUNK) begin
						a = (int'(it.chunk_index) * BYTES_PER_CHUNK + int'(byte_pos))
							% BUF_DEPTH;
						buf_mem[a] = it.data_byte;
						if (!buf_written[a]) begin
							buf_written[a] = 1'b1;
							written_addrs.push_back(a);
						end
						byte_pos++;
					end
				end
				KIND_END: begin
					len = byte_pos;
					bad = bad_bytes || !chunk_ok(it.chunk_index, it.chunk_total);
					byte_pos  = '0;
					bad_bytes = 1'b0;
					if (bad) begin
						drop_assembly();
						r.error_valid = 1'b1;
						r.error_kind  = ERR_BAD;
					end else begin
						if (!assembling) begin
							assembling = 1'b1;
							exp_total  = it.chunk_total[5:0];
							rx_mask    = '0;
						end
						if (int'(it.chunk_index) == int'(exp_total) - 1)
							last_len = len;
						rx_mask[it.chunk_index[4:0]] = 1'b1;
						idle_ticks  = '0;
						r.ack_valid = 1'b1;
						r.ack_index = it.chunk_index[4:0];
						full = (exp_total >= MASK_W) ? '1 : (MASK_W'(1) << exp_total) - 1;
						if (rx_mask == full) begin
							r.complete       = 1'b1;
							r.message_length = MLEN_W'((int'(exp_total) - 1) * BYTES_PER_CHUNK
								+ int'(last_len));
							drop_assembly();
						end
					end
					pending_q.push_back(r);
				end
				KIND_TICK: begin
					if (assembling) begin
						idle_ticks++;
						if (idle_ticks >= timeout_ticks) begin
							drop_assembly();
							r.error_valid = 1'b1;
							r.error_kind  = ERR_TIMEOUT;
							pending_q.push_back(r);
						end
					end
				end
				KIND_PEER: begin
					drop_assembly();
					r.error_valid     = 1'b1;
					r.error_kind      = ERR_PEER;
					r.error_peer_code = it.peer_code;
					pending_q.push_back(r);
				end
				KIND_READ: begin
					r.read_data = buf_mem[it.read_address];
					pending_q.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void cmp_field(string name, logic [15:0] e, logic [15:0] g);
			if (g !== e) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, g);
			end
		endfunction

		// result seen on the port: compare with the oldest prediction
		function void check_result(result_t got);
			result_t e;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				return;
			end
			e = pending_q.pop_front();
			cmp_field("ack_valid",       e.ack_valid,       got.ack_valid);
			cmp_field("ack_index",       e.ack_index,       got.ack_index);
			cmp_field("complete",        e.complete,        got.complete);
			cmp_field("message_length",  e.message_length,  got.message_length);
			cmp_field("error_valid",     e.error_valid,     got.error_valid);
			cmp_field("error_kind",      e.error_kind,      got.error_kind);
			cmp_field("error_peer_code", e.error_peer_code, got.error_peer_code);
			cmp_field("read_data",       e.read_data,       got.read_data);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and dut
	// ------------------------------------------------------------------------
	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          start     = 1'b0;
	logic          busy;
	item_t         item      = '0;
	logic          done;
	result_t       result;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [15:0]   cfg_data  = '0;

	reasm_scoreboard sb;
	bit              gaps_on;
	int              n_sent;    // items that do real work, ticks and unused kinds left out

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	chunk_reassembly_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// monitor: results are checked before the item of the same edge is noted,
	// since a result always belongs to an item taken at an earlier edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_item(item);
			if (cfg_valid && cfg_ready)
				sb.timeout_ticks = cfg_data;
		end
	end

	// hard stop in case the dut hangs
	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// mostly back to back, some short gaps, a few long ones
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function item_t mk(logic [2:0] k, logic [7:0] idx, logic [7:0] tot, logic [7:0] data,
			logic [7:0] code, logic [11:0] addr);
		item_t it;
		it.kind         = k;
		it.chunk_index  = idx;
		it.chunk_total  = tot;
		it.data_byte    = data;
		it.peer_code    = code;
		it.read_address = addr;
		return it;
	endfunction

	// item with the given kind and random payload fields
	function item_t mk_rnd(logic [2:0] k, logic [7:0] idx, logic [7:0] tot);
		return mk(k, idx, tot, 8'($urandom), 8'($urandom), 12'($urandom));
	endfunction

	// present one item at the falling edge and hold it until it is taken;
	// start stays high into the next item when no gap is drawn
	task automatic send(item_t it);
		int g;
		g = pick_gap();
		if (g > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		item  <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (it.kind != KIND_TICK && it.kind <= KIND_READ)
			n_sent++;
	endtask

	// read only from addresses already written, never from fresh buffer cells
	task automatic send_read();
		int a;
		a = sb.pick_written();
		if (a >= 0)
			send(mk(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				12'(a)));
	endtask

	task automatic send_ticks(int n);
		repeat (n) send(mk_rnd(KIND_TICK, 8'($urandom), 8'($urandom)));
	endtask

	// tick run sized so that small timeout settings actually fire
	task automatic tick_burst();
		if (sb.timeout_ticks <= 40)
			send_ticks($urandom_range(1, sb.timeout_ticks + 2));
		else
			send_ticks($urandom_range(1, 4));
	endtask

	// mostly short chunks, now and then a long one that can run past the chunk size
	function int chunk_len();
		if ($urandom_range(0, 99) < 4)
			return $urandom_range(120, BYTES_PER_CHUNK + 4);
		return $urandom_range(0, 4);
	endfunction

	function int pick_total();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 4);
		if (r < 95)
			return $urandom_range(5, 12);
		return $urandom_range(13, MAX_PIECES);
	endfunction

	// bytes of one chunk, with the odd tick or read mixed in, then its end
	task automatic send_chunk(logic [7:0] idx, logic [7:0] tot, int nb);
		int r;
		for (int b = 0; b < nb; b++) begin
			send(mk_rnd(KIND_BYTE, idx, tot));
			r = $urandom_range(0, 99);
			if (r < 6)
				send_ticks(1);
			else if (r < 10)
				send_read();
		end
		send(mk_rnd(KIND_END, idx, tot));
	endtask

	// well-formed message: every chunk once in random order, a few repeats,
	// and now and then a later chunk announcing another total (ignored)
	task automatic send_message(int tot);
		int         order[$];
		int         j;
		int         tmp;
		logic [7:0] tf;
		for (int i = 0; i < tot; i++)
			order.push_back(i);
		for (int i = tot - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < tot; i++) begin
			tf = 8'(tot);
			if (i > 0 && $urandom_range(0, 9) == 0)
				tf = 8'($urandom_range(order[i] + 1, MAX_PIECES));
			send_chunk(8'(order[i]), tf, chunk_len());
			if (i < tot - 1 && $urandom_range(0, 11) == 0)
				send_chunk(8'(order[$urandom_range(0, i)]), 8'(tot), $urandom_range(0, 3));
		end
	endtask

	// start an assembly, then break it or run ticks that may time it out
	task automatic send_broken();
		int tot;
		tot = $urandom_range(2, 8);
		send_chunk(8'($urandom_range(0, tot - 1)), 8'(tot), $urandom_range(0, 3));
		case ($urandom_range(0, 3))
			0: begin
				// byte of a chunk beyond the announced total poisons the next end
				send(mk_rnd(KIND_BYTE, 8'($urandom_range(tot, 255)), 8'(tot)));
				send(mk_rnd(KIND_END, 8'($urandom_range(0, tot - 1)), 8'(tot)));
			end
			1: send(mk_rnd(KIND_END, 8'($urandom_range(tot, MAX_PIECES - 1)),
				8'(MAX_PIECES)));
			2: send(mk_rnd(KIND_END, 8'($urandom_range(0, 3)),
				($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(MAX_PIECES + 1, 255))));
			default: tick_burst();
		endcase
	endtask

	task automatic run_random(int n);
		int target;
		int r;
		target = n_sent + n;
		while (n_sent < target) begin
			if ($urandom_range(0, 9) == 0)
				gaps_on = !gaps_on;
			r = $urandom_range(0, 99);
			if (r < 65) begin
				send_message(pick_total());
			end else if (r < 75) begin
				// noise: any kind, unused codes included, fields fully random but read addresses
				r = $urandom_range(0, KIND_LAST);
				if (r == KIND_READ)
					send_read();
				else
					send(mk_rnd(3'(r), 8'($urandom), 8'($urandom)));
			end else if (r < 80) begin
				send(mk_rnd(KIND_PEER, 8'($urandom), 8'($urandom)));
			end else if (r < 88) begin
				tick_burst();
			end else if (r < 93) begin
				send_read();
			end else begin
				send_broken();
			end
		end
	endtask

	// timeout register write once the engine has drained; a chunk byte gives
	// no result, so the bench idles on after the queue empties, then writes
	task automatic write_timeout(logic [15:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		int w;
		sb      = new();
		n_sent  = 0;
		gaps_on = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed part, default timeout
		send(mk(KIND_PEER, 8'd0, 8'd0, 8'd0, 8'hff, 12'd0));       // peer error while idle
		send(mk(KIND_TICK, 8'hff, 8'hff, 8'hff, 8'h00, 12'hfff));  // tick while idle counts nothing
		send(mk(3'(KIND_LAST), 8'hff, 8'hff, 8'hff, 8'hff, 12'hfff)); // unused kind ignored
		send(mk(KIND_BYTE, 8'd0, 8'd1, 8'hff, 8'd0, 12'd0));
		send(mk(KIND_BYTE, 8'd0, 8'd1, 8'h00, 8'd0, 12'd0));
		send(mk(KIND_END,  8'd0, 8'd1, 8'd0, 8'd0, 12'd0));        // single chunk completes
		send(mk(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 12'd0));
		send(mk(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 12'd1));
		send(mk(KIND_END,  8'd0, 8'd0, 8'd0, 8'd0, 12'd0));        // zero total
		send(mk(KIND_END,  8'd0, 8'd33, 8'd0, 8'd0, 12'd0));       // total above max pieces
		send(mk(KIND_BYTE, 8'd3, 8'd3, 8'h12, 8'd0, 12'd0));       // index not below total
		send(mk(KIND_END,  8'd0, 8'd1, 8'd0, 8'd0, 12'd0));        // ... flagged at the end
		send(mk(KIND_BYTE, 8'd1, 8'd2, 8'haa, 8'd0, 12'd0));
		send(mk(KIND_BYTE, 8'd1, 8'd2, 8'h55, 8'd0, 12'd0));
		send(mk(KIND_END,  8'd1, 8'd2, 8'd0, 8'd0, 12'd0));        // final chunk first
		send(mk(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 12'd0));
		send(mk(KIND_END,  8'd0, 8'd5, 8'd0, 8'd0, 12'd0));        // other total ignored, completes
		send(mk(KIND_END,  8'd31, 8'd32, 8'd0, 8'd0, 12'd0));      // highest index, full mask
		send(mk(KIND_END,  8'd0, 8'd32, 8'd0, 8'd0, 12'd0));
		send(mk(KIND_PEER, 8'd0, 8'd0, 8'd0, 8'h5a, 12'd0));       // peer error mid assembly
		send(mk(KIND_END,  8'd1, 8'd2, 8'd0, 8'd0, 12'd0));
		send(mk(KIND_END,  8'd3, 8'd8, 8'd0, 8'd0, 12'd0));        // index past stored total
		send(mk(KIND_BYTE, 8'd0, 8'd1, 8'h80, 8'd0, 12'd0));
		send(mk(KIND_END,  8'd0, 8'd1, 8'd0, 8'd0, 12'd0));

		// overlong last chunk of a full-size message fills the top of the buffer
		gaps_on = 1'b1;
		send_chunk(8'(MAX_PIECES - 1), 8'(MAX_PIECES), BYTES_PER_CHUNK + 2);
		send(mk_rnd(KIND_PEER, 8'($urandom), 8'($urandom)));
		run_random(15);

		// shortest timeout: first tick while assembling abandons it
		write_timeout(16'd1);
		run_random(30);

		// longest timeout, back to back
		write_timeout(16'hffff);
		gaps_on = 1'b0;
		run_random(30);

		write_timeout(16'd3);
		gaps_on = 1'b1;
		run_random(50);

		write_timeout(16'($urandom_range(2, 40)));
		run_random(50);

		write_timeout(TIMEOUT_RESET);
		run_random(15);

		// drain, then let the clock run on before the final check
		@(negedge clk);
		start <= 1'b0;
		for (w = 0; w < 1000 && sb.pending() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d results expected but never seen", $time, sb.pending());
		end
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cra_pkg.sv
rtl/cra_ram.sv
rtl/chunk_reassembly_engine.sv
sim/tb_chunk_reassembly_engine.sv
